@@ rtl/bpat_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the beacon period anomaly table
// no dependencies

package bpat_pkg;

    localparam int ADDR_W   = 32;
    localparam int TICK_W   = 32;
    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] STATUS_STEADY   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NETCHG   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NEW      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_REMOVED  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd5;

    localparam logic OP_BEACON = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] server_addr;
        logic [TICK_W-1:0] now_ticks;
    } beacon_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TICK_W-1:0]   period_ticks;
        logic [TICK_W-1:0]   average_ticks;
    } result_t;

    // lookup outcome handed from the match stage to the update math
    typedef struct packed {
        logic op;
        logic hit;
        logic free;
    } lookup_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MATCH,
        ST_CALC,
        ST_UPDATE
    } state_t;

endpackage

@@ rtl/bpat_ram.sv @@
`timescale 1ns / 1ps
// generic single-write, single-read synchronous ram with registered read
// no dependencies

module bpat_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bpat_calc.sv @@
`timescale 1ns / 1ps
// average update and net change test for one looked-up entry
// depends on bpat_pkg

module bpat_calc
    import bpat_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  lookup_t                 lookup,
    input  logic [TIME_WIDTH-1:0]   period,
    input  logic [TIME_WIDTH-1:0]   avg_old,
    output logic [STATUS_W-1:0]     status,
    output logic [TIME_WIDTH-1:0]   period_out,
    output logic [TIME_WIDTH-1:0]   avg_new
);

    logic [TIME_WIDTH-1:0] avg_sum;
    logic                  netchg;

    // floor((a + p) / 2) without a carry bit
    assign avg_sum = (avg_old >> 1) + (period >> 1)
                   + TIME_WIDTH'(avg_old[0] & period[0]);
    assign netchg  = (avg_sum <= (period >> 2)) || (period <= (avg_sum >> 1));

    always_comb
    begin
        status     = STATUS_FULL;
        period_out = '0;
        avg_new    = '0;
        if (lookup.op == OP_REMOVE)
        begin
            status = lookup.hit ? STATUS_REMOVED : STATUS_NOTFOUND;
        end
        else if (lookup.hit)
        begin
            status     = netchg ? STATUS_NETCHG : STATUS_STEADY;
            period_out = period;
            avg_new    = avg_sum;
        end
        else if (lookup.free)
        begin
            status = STATUS_NEW;
        end
    end

endmodule

@@ rtl/beacon_period_anomaly_table_top.sv @@
`timescale 1ns / 1ps
// flow: a beacon word accepted in idle steps through read, match, calc and
// update on the single bucket memory before the next is taken; the result
// word is registered on commit in update, held off while a result is stalled
// reset: control clears at once, then a clearing pass zeroes every bucket row
// while beacon_stall stays high

module beacon_period_anomaly_table_top
    import bpat_pkg::*;
#(
    parameter int BUCKET_BITS = 8,
    parameter int WAYS        = 4,
    parameter int TIME_WIDTH  = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    beacon_valid,
    output logic    beacon_stall,
    input  beacon_t beacon,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int EW    = 1 + ADDR_W + 2 * TIME_WIDTH;
    localparam int RW    = WAYS * EW;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROWS  = 1 << BUCKET_BITS;

    state_t                  state_reg, state_next;
    beacon_t                 item_reg;
    logic [BUCKET_BITS-1:0]  clr_cnt_reg;
    logic [RW-1:0]           row_reg;
    logic                    hit_reg, free_reg;
    logic [WAY_W-1:0]        way_reg;
    logic [TIME_WIDTH-1:0]   stamp_reg, avg_reg, period_reg;
    result_t                 result_reg;
    logic                    result_valid_reg;

    logic [RW-1:0]           rd_row, new_row, ram_wdata;
    logic [BUCKET_BITS-1:0]  bucket, ram_waddr;
    logic                    ram_we, commit;
    logic [TIME_WIDTH-1:0]   now_tw;

    logic                    hit, free;
    logic [WAY_W-1:0]        hit_way, free_way;
    logic [TIME_WIDTH-1:0]   stamp_sel, avg_sel;
    logic [EW-1:0]           ent;

    lookup_t                 lookup;
    logic [STATUS_W-1:0]     calc_status;
    logic [TIME_WIDTH-1:0]   calc_period, calc_avg;

    assign bucket = item_reg.server_addr[BUCKET_BITS-1:0];
    assign now_tw = TIME_WIDTH'(item_reg.now_ticks);

    bpat_ram #(
        .WIDTH (RW),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (bucket),
        .rdata (rd_row)
    );

    // way search over the bucket row, lowest way wins
    always_comb
    begin
        ent       = '0;
        hit       = 1'b0;
        free      = 1'b0;
        hit_way   = '0;
        free_way  = '0;
        stamp_sel = '0;
        avg_sel   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            ent = rd_row[w*EW +: EW];
            if (!hit && ent[EW-1] && (ent[EW-2 -: ADDR_W] == item_reg.server_addr))
            begin
                hit       = 1'b1;
                hit_way   = WAY_W'(w);
                stamp_sel = ent[2*TIME_WIDTH-1 : TIME_WIDTH];
                avg_sel   = ent[TIME_WIDTH-1:0];
            end
            if (!free && !ent[EW-1])
            begin
                free     = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    assign lookup = '{op: item_reg.op, hit: hit_reg, free: free_reg};

    bpat_calc #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_calc (
        .lookup     (lookup),
        .period     (period_reg),
        .avg_old    (avg_reg),
        .status     (calc_status),
        .period_out (calc_period),
        .avg_new    (calc_avg)
    );

    // row written back on commit
    always_comb
    begin
        new_row = row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == way_reg)
            begin
                if (item_reg.op == OP_REMOVE)
                begin
                    if (hit_reg)
                    begin
                        new_row[w*EW + EW - 1] = 1'b0;
                    end
                end
                else if (hit_reg)
                begin
                    new_row[w*EW +: 2*TIME_WIDTH] = {now_tw, calc_avg};
                end
                else if (free_reg)
                begin
                    new_row[w*EW +: EW] = {1'b1, item_reg.server_addr, now_tw,
                                           {TIME_WIDTH{1'b0}}};
                end
            end
        end
    end

    assign commit = (state_reg == ST_UPDATE) && (!result_valid_reg || !result_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == BUCKET_BITS'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (beacon_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_MATCH;
            ST_MATCH:  state_next = ST_CALC;
            ST_CALC:   state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        beacon_stall = 1'b1;
        ram_we       = 1'b0;
        ram_waddr    = bucket;
        ram_wdata    = new_row;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                beacon_stall = 1'b0;
            end
            ST_UPDATE:
            begin
                ram_we = commit;
            end
            default:
            begin
                beacon_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (commit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (beacon_valid && !beacon_stall)
        begin
            item_reg <= beacon;
        end
        if (state_reg == ST_MATCH)
        begin
            row_reg   <= rd_row;
            hit_reg   <= hit;
            free_reg  <= free;
            way_reg   <= hit ? hit_way : free_way;
            stamp_reg <= stamp_sel;
            avg_reg   <= avg_sel;
        end
        if (state_reg == ST_CALC)
        begin
            period_reg <= now_tw - stamp_reg;
        end
        if (commit)
        begin
            result_reg.status        <= calc_status;
            result_reg.period_ticks  <= TICK_W'(calc_period);
            result_reg.average_ticks <= TICK_W'(calc_avg);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    // a result word only appears out of the update step
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == ST_UPDATE)
        else $error("result word raised outside update");

    // memory is written only by the clearing pass or a commit
    a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR) || (state_reg == ST_UPDATE))
        else $error("unexpected memory write");

    // statuses other than steady and net change carry no period or average
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == STATUS_NEW || result.status == STATUS_FULL ||
                         result.status == STATUS_REMOVED ||
                         result.status == STATUS_NOTFOUND)
        |-> result.period_ticks == '0 && result.average_ticks == '0)
        else $error("nonzero period on entry status");

    // a word in flight steps from read through match to calc
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_MATCH) ##1 (state_reg == ST_CALC))
        else $error("sequencer skipped a step");
`endif

endmodule
